### rtl/quoted_argument_tokenizer_macros.svh
// Assertion macros for the quoted argument tokenizer checker.
// Used by the checker file only; depends on nothing else.
`ifndef QUOTED_ARGUMENT_TOKENIZER_MACROS_SVH
`define QUOTED_ARGUMENT_TOKENIZER_MACROS_SVH

// Check that a condition implies a consequence in the same cycle
`define QAT_ASSERT_NOW(label, cond, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (cons)) \
        else $error("tokenizer check failed");

// Check that a condition implies a consequence in the following cycle
`define QAT_ASSERT_NEXT(label, cond, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (cons)) \
        else $error("tokenizer check failed");

`endif

### rtl/qat_pkg.sv
// Shared types and constants for the quoted argument tokenizer.
// Used by qat_step and the top level; depends on nothing.
package qat_pkg;

    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned TDATA_W = 16;
    localparam int unsigned TUSER_W = 2;

    localparam logic [CHAR_W-1:0] CH_DQUOTE = 8'h22;
    localparam logic [CHAR_W-1:0] CH_SQUOTE = 8'h27;
    localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;
    localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;

    // Parse mode of the scanner
    typedef enum logic [2:0] {
        MODE_BETWEEN     = 3'd0,
        MODE_WORD        = 3'd1,
        MODE_QUOTED      = 3'd2,
        MODE_ESCAPE      = 3'd3,
        MODE_AFTER_QUOTE = 3'd4,
        MODE_SKIP        = 3'd5
    } qat_mode_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK            = 2'd0,
        ST_MISSING_QUOTE = 2'd1,
        ST_EXPECT_SPACE  = 2'd2
    } qat_status_t;

    // One result item
    typedef struct packed {
        logic              has_char;
        logic [CHAR_W-1:0] out_char;
        logic              arg_start;
        logic              arg_end;
        logic              line_done;
        qat_status_t       status;
        logic              run_last;
    } qat_result_t;

    // Outcome of one character: next state and up to two results
    typedef struct packed {
        qat_mode_t   mode_next;
        logic        quote_single_next;
        logic [1:0]  count;
        qat_result_t res0;
        qat_result_t res1;
    } qat_step_t;

endpackage

### rtl/qat_step.sv
// Next-state and result decode for one character of the command line.
// Purely combinational; depends on qat_pkg.
module qat_step (
    input  qat_pkg::qat_mode_t         mode_i,
    input  logic                       quote_single_i,
    input  logic [qat_pkg::CHAR_W-1:0] char_i,
    input  logic                       last_i,
    output qat_pkg::qat_step_t         step_o
);
    import qat_pkg::*;

    logic              sep;
    logic              is_quote;
    logic [CHAR_W-1:0] quote_char;

    function automatic qat_result_t mk_res(input logic has, input logic [CHAR_W-1:0] ch,
                                           input logic start, input logic fin,
                                           input logic done, input qat_status_t st);
        qat_result_t r;
        r.has_char  = has;
        r.out_char  = ch;
        r.arg_start = start;
        r.arg_end   = fin;
        r.line_done = done;
        r.status    = st;
        r.run_last  = 1'b0;
        return r;
    endfunction

    assign sep        = (char_i == CH_SPACE) || (char_i == CH_TAB);
    assign is_quote   = (char_i == CH_DQUOTE) || (char_i == CH_SQUOTE);
    assign quote_char = quote_single_i ? CH_SQUOTE : CH_DQUOTE;

    // Decode the character against the current mode
    always_comb begin
        step_o                   = '0;
        step_o.mode_next         = mode_i;
        step_o.quote_single_next = quote_single_i;
        unique case (mode_i)
            MODE_BETWEEN: begin
                if (sep) begin
                    if (last_i) begin
                        step_o.res0  = mk_res(1'b0, '0, 1'b0, 1'b0, 1'b1, ST_OK);
                        step_o.count = 2'd1;
                    end
                end else if (is_quote) begin
                    if (last_i) begin
                        step_o.res0 = mk_res(1'b0, '0, 1'b0, 1'b0, 1'b1, ST_MISSING_QUOTE);
                    end else begin
                        step_o.quote_single_next = (char_i == CH_SQUOTE);
                        step_o.res0      = mk_res(1'b0, '0, 1'b1, 1'b0, 1'b0, ST_OK);
                        step_o.mode_next = MODE_QUOTED;
                    end
                    step_o.count = 2'd1;
                end else begin
                    step_o.res0      = mk_res(1'b1, char_i, 1'b1, last_i, last_i, ST_OK);
                    step_o.count     = 2'd1;
                    step_o.mode_next = MODE_WORD;
                end
            end
            MODE_WORD: begin
                if (sep) begin
                    step_o.res0      = mk_res(1'b0, '0, 1'b0, 1'b1, last_i, ST_OK);
                    step_o.mode_next = MODE_BETWEEN;
                end else begin
                    step_o.res0 = mk_res(1'b1, char_i, 1'b0, last_i, last_i, ST_OK);
                end
                step_o.count = 2'd1;
            end
            MODE_QUOTED: begin
                if (char_i == quote_char) begin
                    step_o.res0      = mk_res(1'b0, '0, 1'b0, 1'b1, last_i, ST_OK);
                    step_o.count     = 2'd1;
                    step_o.mode_next = MODE_AFTER_QUOTE;
                end else if (last_i) begin
                    step_o.res0  = mk_res(1'b0, '0, 1'b0, 1'b0, 1'b1, ST_MISSING_QUOTE);
                    step_o.count = 2'd1;
                end else if (char_i == CH_BSLASH) begin
                    step_o.mode_next = MODE_ESCAPE;
                end else begin
                    step_o.res0  = mk_res(1'b1, char_i, 1'b0, 1'b0, 1'b0, ST_OK);
                    step_o.count = 2'd1;
                end
            end
            MODE_ESCAPE: begin
                if (last_i) begin
                    step_o.res0  = mk_res(1'b0, '0, 1'b0, 1'b0, 1'b1, ST_MISSING_QUOTE);
                    step_o.count = 2'd1;
                end else if ((char_i == quote_char) || (char_i == CH_BSLASH)) begin
                    step_o.res0  = mk_res(1'b1, char_i, 1'b0, 1'b0, 1'b0, ST_OK);
                    step_o.count = 2'd1;
                end else begin
                    // Keep both the backslash and the character
                    step_o.res0  = mk_res(1'b1, CH_BSLASH, 1'b0, 1'b0, 1'b0, ST_OK);
                    step_o.res1  = mk_res(1'b1, char_i, 1'b0, 1'b0, 1'b0, ST_OK);
                    step_o.count = 2'd2;
                end
                step_o.mode_next = MODE_QUOTED;
            end
            MODE_AFTER_QUOTE: begin
                if (sep) begin
                    if (last_i) begin
                        step_o.res0  = mk_res(1'b0, '0, 1'b0, 1'b0, 1'b1, ST_OK);
                        step_o.count = 2'd1;
                    end
                    step_o.mode_next = MODE_BETWEEN;
                end else begin
                    step_o.res0      = mk_res(1'b0, '0, 1'b0, 1'b0, last_i, ST_EXPECT_SPACE);
                    step_o.count     = 2'd1;
                    step_o.mode_next = MODE_SKIP;
                end
            end
            default: begin
                // Skip the rest of the line after an error
                if (last_i) begin
                    step_o.res0  = mk_res(1'b0, '0, 1'b0, 1'b0, 1'b1, ST_OK);
                    step_o.count = 2'd1;
                end
            end
        endcase

        // Return to the idle state at the end of the line
        if (last_i) begin
            step_o.mode_next         = MODE_BETWEEN;
            step_o.quote_single_next = 1'b0;
        end

        // Flag the final result of this character
        if (step_o.count == 2'd1) begin
            step_o.res0.run_last = 1'b1;
        end
        if (step_o.count == 2'd2) begin
            step_o.res1.run_last = 1'b1;
        end
    end

endmodule

### rtl/quoted_argument_tokenizer.sv
// Top level of the quoted argument tokenizer: handshakes, state and result registers.
// Depends on qat_pkg and qat_step.
//
//  Channel  Direction  Payload
//  s_       in         tdata[7:0] char_code, tlast line_last
//  m_       out        tdata has_char/out_char/arg_start/arg_end/run_last,
//                      tlast line_done, tuser status
//
// One character is taken per cycle while s_tready is high; its first result appears in
// the output register on the following cycle. A kept escape inside quotes gives a second
// result, held in a one-entry overflow register, and holds s_tready low until it has
// moved on to the output register, which waits while m_tready is low.
// Reset (aresetn low, synchronous) empties both result registers and returns the
// scanner to the between-arguments state. s_tready stays high while m_tready is low
// only as long as the output register is empty.
module quoted_argument_tokenizer (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [qat_pkg::CHAR_W-1:0]  s_tdata,   // [7:0] char_code
    input  logic                        s_tlast,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [qat_pkg::TDATA_W-1:0] m_tdata,   // [0] has_char, [8:1] out_char,
                                                   // [9] arg_start, [10] arg_end,
                                                   // [11] run_last, [15:12] zero
    output logic                        m_tlast,
    output logic [qat_pkg::TUSER_W-1:0] m_tuser    // [1:0] status
);
    import qat_pkg::*;

    qat_mode_t   mode_reg,        mode_next;
    logic        quote_single_reg, quote_single_next;
    logic        out_vld_reg,     out_vld_next;
    qat_result_t out_res_reg,     out_res_next;
    logic        pend_vld_reg,    pend_vld_next;
    qat_result_t pend_res_reg,    pend_res_next;

    logic        out_free;
    logic        s_accept;
    qat_step_t   step;

    qat_step u_step (
        .mode_i         (mode_reg),
        .quote_single_i (quote_single_reg),
        .char_i         (s_tdata),
        .last_i         (s_tlast),
        .step_o         (step)
    );

    assign out_free = !out_vld_reg || m_tready;
    assign s_tready = !pend_vld_reg && out_free;
    assign s_accept = s_tvalid && s_tready;

    // Advance the scanner and load the result registers
    always_comb begin
        mode_next         = mode_reg;
        quote_single_next = quote_single_reg;
        out_vld_next      = out_vld_reg;
        out_res_next      = out_res_reg;
        pend_vld_next     = pend_vld_reg;
        pend_res_next     = pend_res_reg;

        if (out_free) begin
            out_vld_next = 1'b0;
        end
        if (pend_vld_reg && out_free) begin
            // Drain the held second result
            out_vld_next  = 1'b1;
            out_res_next  = pend_res_reg;
            pend_vld_next = 1'b0;
        end
        if (s_accept) begin
            mode_next         = step.mode_next;
            quote_single_next = step.quote_single_next;
            if (step.count != 2'd0) begin
                out_vld_next = 1'b1;
                out_res_next = step.res0;
            end
            if (step.count == 2'd2) begin
                pend_vld_next = 1'b1;
                pend_res_next = step.res1;
            end
        end
    end

    // Hold control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg         <= MODE_BETWEEN;
            quote_single_reg <= 1'b0;
            out_vld_reg      <= 1'b0;
            pend_vld_reg     <= 1'b0;
        end else begin
            mode_reg         <= mode_next;
            quote_single_reg <= quote_single_next;
            out_vld_reg      <= out_vld_next;
            pend_vld_reg     <= pend_vld_next;
        end
    end

    // Hold result payloads
    always_ff @(posedge aclk) begin
        out_res_reg  <= out_res_next;
        pend_res_reg <= pend_res_next;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {4'b0000, out_res_reg.run_last, out_res_reg.arg_end,
                       out_res_reg.arg_start, out_res_reg.out_char, out_res_reg.has_char};
    assign m_tlast  = out_res_reg.line_done;
    assign m_tuser  = out_res_reg.status;

endmodule

### rtl/qat_checker.sv
// Port-level checks for the quoted argument tokenizer, bound to the top level.
// Depends on qat_pkg and quoted_argument_tokenizer_macros.svh.
`include "quoted_argument_tokenizer_macros.svh"

module qat_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_tvalid,
    input logic                        s_tready,
    input logic                        s_tlast,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [qat_pkg::TDATA_W-1:0] m_tdata,
    input logic                        m_tlast,
    input logic [qat_pkg::TUSER_W-1:0] m_tuser
);
    import qat_pkg::*;

    logic                       m_hold;
    logic [TDATA_W+TUSER_W:0]   m_word;
    logic                       m_err;
    logic                       err_shape_ok;
    logic                       line_in;

    assign m_hold       = m_tvalid && !m_tready;
    assign m_word       = {m_tdata, m_tlast, m_tuser};
    assign m_err        = m_tvalid && (m_tuser != ST_OK);
    assign err_shape_ok = !m_tdata[0] && !m_tdata[9] && !m_tdata[10] && m_tdata[11]
                          && (m_tuser <= ST_EXPECT_SPACE);
    assign line_in      = s_tvalid && s_tready && s_tlast;

    // A stalled transfer keeps its payload
    `QAT_ASSERT_NEXT(a_stall_hold, m_hold, m_tvalid && $stable(m_word))

    // The last character of a line is answered by a line end in the next cycle
    `QAT_ASSERT_NEXT(a_line_answered, line_in, m_tvalid && m_tlast)

    // The end of a line is always the last result of its character
    `QAT_ASSERT_NOW(a_done_run_last, m_tvalid && m_tlast, m_tdata[11])

    // A result without a character carries a zero byte
    `QAT_ASSERT_NOW(a_empty_char, m_tvalid && !m_tdata[0], m_tdata[8:1] == 8'h00)

    // An error result carries no character or marks and closes its run
    `QAT_ASSERT_NOW(a_error_shape, m_err, err_shape_ok)

endmodule

bind quoted_argument_tokenizer qat_checker u_qat_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

### sim/quoted_argument_tokenizer_tb.sv
// Self-checking testbench for quoted_argument_tokenizer: command lines in, argument tokens out.
// Predicts every token from its own scanner model and compares each m_ transfer in order.
// Depends on qat_pkg and the RTL of the top level only.
module quoted_argument_tokenizer_tb;
    import qat_pkg::*;

    localparam int STALL_LIMIT = 1000;
    localparam int LINE_ITEMS  = 1300;

    // One pending character of a command line
    typedef struct {
        logic [7:0] code;
        logic       eol;
        bit         wait_drain;
    } char_item_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [CHAR_W-1:0]    s_tdata  = '0;
    logic                 s_tlast  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [TDATA_W-1:0]   m_tdata;
    logic                 m_tlast;
    logic [TUSER_W-1:0]   m_tuser;

    char_item_t  char_q [$];
    logic [7:0]  line_buf [$];
    qat_result_t token_q [$];

    // Scanner state of the predictor
    qat_mode_t   scan_mode = MODE_BETWEEN;
    logic        in_single = 1'b0;

    bit          char_taken  = 1'b0;
    int          n_taken     = 0;
    int          n_total     = 0;
    int          fault_count = 0;
    int          stall_cycles = 0;
    int          line_no     = 0;

    quoted_argument_tokenizer dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always #5 aclk = ~aclk;

    task automatic report_mismatch(input string what, input int got_v, input int ref_v);
        fault_count++;
        if (fault_count <= 40)
            $display("quoted_argument_tokenizer_tb: mismatch on %s: got %0h, expected %0h at %0t",
                     what, got_v, ref_v, $time);
    endtask

    task automatic check_field(input string what, input int got_v, input int ref_v);
        if (got_v != ref_v) report_mismatch(what, got_v, ref_v);
    endtask

    function automatic qat_result_t token_of(input logic has, input logic [7:0] ch,
                                             input logic opens, input logic closes,
                                             input logic done, input qat_status_t st);
        qat_result_t r;
        r.has_char  = has;
        r.out_char  = ch;
        r.arg_start = opens;
        r.arg_end   = closes;
        r.line_done = done;
        r.status    = st;
        r.run_last  = 1'b0;
        return r;
    endfunction

    // Advance the scanner by one character and queue the tokens it yields
    function automatic void predict_tokens(input logic [7:0] c, input logic eol);
        qat_result_t res [2];
        int          n;
        logic        sep;
        logic [7:0]  q;
        n   = 0;
        sep = (c == CH_SPACE) || (c == CH_TAB);
        q   = in_single ? CH_SQUOTE : CH_DQUOTE;
        case (scan_mode)
            MODE_BETWEEN: begin
                if (sep) begin
                    if (eol) begin
                        res[n] = token_of(1'b0, 8'h00, 1'b0, 1'b0, 1'b1, ST_OK);
                        n++;
                    end
                end else if (c == CH_DQUOTE || c == CH_SQUOTE) begin
                    if (eol) begin
                        res[n] = token_of(1'b0, 8'h00, 1'b0, 1'b0, 1'b1, ST_MISSING_QUOTE);
                        n++;
                    end else begin
                        in_single = (c == CH_SQUOTE);
                        res[n] = token_of(1'b0, 8'h00, 1'b1, 1'b0, 1'b0, ST_OK);
                        n++;
                        scan_mode = MODE_QUOTED;
                    end
                end else begin
                    res[n] = token_of(1'b1, c, 1'b1, eol, eol, ST_OK);
                    n++;
                    scan_mode = MODE_WORD;
                end
            end
            MODE_WORD: begin
                if (sep) begin
                    res[n] = token_of(1'b0, 8'h00, 1'b0, 1'b1, eol, ST_OK);
                    scan_mode = MODE_BETWEEN;
                end else begin
                    res[n] = token_of(1'b1, c, 1'b0, eol, eol, ST_OK);
                end
                n++;
            end
            MODE_QUOTED: begin
                if (c == q) begin
                    res[n] = token_of(1'b0, 8'h00, 1'b0, 1'b1, eol, ST_OK);
                    n++;
                    scan_mode = MODE_AFTER_QUOTE;
                end else if (eol) begin
                    res[n] = token_of(1'b0, 8'h00, 1'b0, 1'b0, 1'b1, ST_MISSING_QUOTE);
                    n++;
                end else if (c == CH_BSLASH) begin
                    scan_mode = MODE_ESCAPE;
                end else begin
                    res[n] = token_of(1'b1, c, 1'b0, 1'b0, 1'b0, ST_OK);
                    n++;
                end
            end
            MODE_ESCAPE: begin
                if (eol) begin
                    res[n] = token_of(1'b0, 8'h00, 1'b0, 1'b0, 1'b1, ST_MISSING_QUOTE);
                    n++;
                end else if (c == q || c == CH_BSLASH) begin
                    res[n] = token_of(1'b1, c, 1'b0, 1'b0, 1'b0, ST_OK);
                    n++;
                end else begin
                    res[0] = token_of(1'b1, CH_BSLASH, 1'b0, 1'b0, 1'b0, ST_OK);
                    res[1] = token_of(1'b1, c, 1'b0, 1'b0, 1'b0, ST_OK);
                    n = 2;
                end
                scan_mode = MODE_QUOTED;
            end
            MODE_AFTER_QUOTE: begin
                if (sep) begin
                    if (eol) begin
                        res[n] = token_of(1'b0, 8'h00, 1'b0, 1'b0, 1'b1, ST_OK);
                        n++;
                    end
                    scan_mode = MODE_BETWEEN;
                end else begin
                    res[n] = token_of(1'b0, 8'h00, 1'b0, 1'b0, eol, ST_EXPECT_SPACE);
                    n++;
                    scan_mode = MODE_SKIP;
                end
            end
            default: begin
                if (eol) begin
                    res[n] = token_of(1'b0, 8'h00, 1'b0, 1'b0, 1'b1, ST_OK);
                    n++;
                end
            end
        endcase
        if (eol) begin
            scan_mode = MODE_BETWEEN;
            in_single = 1'b0;
        end
        if (n > 0) res[n-1].run_last = 1'b1;
        for (int i = 0; i < n; i++) token_q.push_back(res[i]);
    endfunction

    // Stimulus helpers: build a line in line_buf, then move it to the send queue
    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
    endtask

    task automatic flush_line(input bit drain);
        char_item_t it;
        for (int i = 0; i < line_buf.size(); i++) begin
            it.code       = line_buf[i];
            it.eol        = (i == line_buf.size() - 1);
            it.wait_drain = drain && (i == 0);
            char_q.push_back(it);
        end
        line_buf.delete();
    endtask

    function automatic logic [7:0] any_byte();
        case ($urandom_range(0, 9))
            0: return CH_DQUOTE;
            1: return CH_SQUOTE;
            2: return CH_BSLASH;
            3: return CH_SPACE;
            4: return CH_TAB;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] word_byte();
        logic [7:0] c;
        do c = any_byte(); while (c == CH_SPACE || c == CH_TAB);
        return c;
    endfunction

    function automatic logic [7:0] sep_byte();
        return $urandom_range(0, 1) ? CH_SPACE : CH_TAB;
    endfunction

    task automatic add_word();
        logic [7:0] c;
        int         len;
        len = $urandom_range(1, 6);
        do c = word_byte(); while (c == CH_DQUOTE || c == CH_SQUOTE);
        line_buf.push_back(c);
        for (int i = 1; i < len; i++) line_buf.push_back(word_byte());
    endtask

    // Quoted argument; a messy one may lose its closing quote or be glued to a word
    task automatic add_quoted(input bit messy);
        logic [7:0] q;
        logic [7:0] c;
        int         len;
        q   = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
        len = $urandom_range(0, 6);
        line_buf.push_back(q);
        for (int i = 0; i < len; i++) begin
            case ($urandom_range(0, 5))
                0: begin
                    line_buf.push_back(CH_BSLASH);
                    line_buf.push_back(q);
                end
                1: begin
                    line_buf.push_back(CH_BSLASH);
                    line_buf.push_back(CH_BSLASH);
                end
                2: begin
                    do c = any_byte(); while (c == q || c == CH_BSLASH);
                    line_buf.push_back(CH_BSLASH);
                    line_buf.push_back(c);
                end
                default: begin
                    do c = any_byte(); while (c == q || c == CH_BSLASH);
                    line_buf.push_back(c);
                end
            endcase
        end
        if (messy && $urandom_range(0, 1)) return;
        line_buf.push_back(q);
        if (messy) line_buf.push_back(word_byte());
    endtask

    task automatic add_random_line();
        int  kind;
        int  nargs;
        bit  messy;
        kind = $urandom_range(0, 99);
        if (kind < 10) begin
            nargs = $urandom_range(1, 12);
            for (int i = 0; i < nargs; i++) line_buf.push_back(any_byte());
        end else begin
            messy = (kind < 25);
            nargs = $urandom_range(1, 4);
            if ($urandom_range(0, 3) == 0) line_buf.push_back(sep_byte());
            for (int i = 0; i < nargs; i++) begin
                if (i > 0) begin
                    line_buf.push_back(sep_byte());
                    if ($urandom_range(0, 2) == 0) line_buf.push_back(sep_byte());
                end
                if ($urandom_range(0, 1)) add_word();
                else add_quoted(messy && $urandom_range(0, 1));
            end
            if ($urandom_range(0, 3) == 0) line_buf.push_back(sep_byte());
        end
        flush_line(line_no % 25 == 0);
        line_no++;
    endtask

    // Drive the s_ channel and m_tready at the falling edge
    always @(negedge aclk) begin
        bit took;
        int phase;
        int send_idle;
        int recv_idle;
        took = char_taken;
        char_taken = 1'b0;
        if (took) char_q.delete(0);
        phase = (n_total > 0) ? (n_taken * 3) / n_total : 0;
        case (phase)
            0: begin
                send_idle = 20;
                recv_idle = 77;
            end
            1: begin
                send_idle = 77;
                recv_idle = 20;
            end
            default: begin
                send_idle = 0;
                recv_idle = 0;
            end
        endcase
        m_tready <= aresetn && ($urandom_range(0, 99) >= recv_idle);
        // hold an offered character until it is taken
        if (!s_tvalid || took) begin
            if (aresetn && char_q.size() > 0
                    && !(char_q[0].wait_drain && token_q.size() != 0)
                    && $urandom_range(0, 99) >= send_idle) begin
                s_tvalid <= 1'b1;
                s_tdata  <= char_q[0].code;
                s_tlast  <= char_q[0].eol;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Check tokens, predict from accepted characters, and watch for a hang
    always @(posedge aclk) begin
        qat_result_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (token_q.size() == 0) begin
                    report_mismatch("unexpected token", int'(m_tdata), 0);
                end else begin
                    want = token_q.pop_front();
                    check_field("has_char",  int'(m_tdata[0]),   int'(want.has_char));
                    check_field("out_char",  int'(m_tdata[8:1]), int'(want.out_char));
                    check_field("arg_start", int'(m_tdata[9]),   int'(want.arg_start));
                    check_field("arg_end",   int'(m_tdata[10]),  int'(want.arg_end));
                    check_field("run_last",  int'(m_tdata[11]),  int'(want.run_last));
                    check_field("line_done", int'(m_tlast),      int'(want.line_done));
                    check_field("status",    int'(m_tuser),      int'(want.status));
                end
            end
            if (s_tvalid && s_tready) begin
                predict_tokens(s_tdata, s_tlast);
                n_taken++;
                char_taken = 1'b1;
            end
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) stall_cycles = 0;
            else stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("quoted_argument_tokenizer_tb: FAIL");
                $finish;
            end
        end
    end

    initial begin
        // separators only, ending on a tab
        put_text(" \t");
        flush_line(1'b0);
        // word made of the lowest and highest byte values
        line_buf.push_back(8'h00);
        line_buf.push_back(8'hFF);
        flush_line(1'b0);
        // quote opening on the last byte
        put_text("\"");
        flush_line(1'b0);
        // escaped quote, escaped backslash, kept escape, then no space after the close
        put_text("'\\'\\\\\\x'z");
        flush_line(1'b0);
        // empty quotes, a word, then a backslash on the last byte
        put_text("\"\" k \"\\");
        flush_line(1'b1);
        // other quote kind is literal, then bytes skipped after the error
        put_text("\"'\"qw");
        flush_line(1'b0);
        while (char_q.size() < LINE_ITEMS) add_random_line();
        n_total = char_q.size();

        repeat (12) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        wait (n_taken == n_total);
        while (token_q.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
        if (fault_count == 0) begin
            $display("quoted_argument_tokenizer_tb: PASS");
        end else begin
            $display("quoted_argument_tokenizer_tb: FAIL");
        end
        $finish;
    end

endmodule
